/* hw/rtl/sorted_wakeup_time_queue_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef SORTED_WAKEUP_TIME_QUEUE_UNIT_ASSERT_SVH
`define SORTED_WAKEUP_TIME_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SWTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define SWTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/swtq_pkg.sv */
package swtq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 64;
    localparam int unsigned KEY_MS_PER_S    = 1000;

    localparam int unsigned TERM_W  = 16;
    localparam int unsigned TAG_W   = 3;
    localparam int unsigned KEY_W   = 8;
    localparam int unsigned THINK_W = 24;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned FILL_W  = 7;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic capture;
        logic calc;
        logic apply;
    } t_cmd;

endpackage

/* hw/rtl/swtq_if.sv */
interface swtq_req_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [swtq_pkg::TERM_W-1:0]        terminal;
    logic [swtq_pkg::TAG_W-1:0]         tag;
    logic [swtq_pkg::KEY_W-1:0]         keying_seconds;
    logic [swtq_pkg::THINK_W-1:0]       think_ms;

    modport source (output valid, action, terminal, tag, keying_seconds, think_ms,
                    input ready);
    modport sink (input valid, action, terminal, tag, keying_seconds, think_ms,
                  output ready);
endinterface

interface swtq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic [swtq_pkg::TERM_W-1:0]        out_terminal;
    logic [swtq_pkg::TAG_W-1:0]         out_tag;
    logic [swtq_pkg::TIME_W-1:0]        delay_ms;
    logic [swtq_pkg::FILL_W-1:0]        fill;

    modport source (output valid, status, out_terminal, out_tag, delay_ms, fill,
                    input ready);
    modport sink (input valid, status, out_terminal, out_tag, delay_ms, fill,
                  output ready);
endinterface

/* hw/rtl/sorted_wakeup_time_queue_unit.sv */
// Time-ordered wake-up queue of up to QUEUE_DEPTH terminals. An enqueue word
// computes due = keying_seconds*1000 + think_ms + queue time (mod 2^32) and
// inserts it into a sorted chain of register cells; equal due times leave
// newest first. A dequeue pops the earliest entry, returns its terminal, tag
// and the delay since the queue time, and moves the queue time to its due
// time. Status flags full and empty instead of blocking. After a word is
// accepted, the due-time add and then the cell-chain update run in turn, and
// the result word is registered with the update; the next word is accepted
// only after that update, so words do not overlap. A stalled result holds
// the chain update of the following word. A new word is accepted while the
// previous result waits. fill is the count modulo 128.
module sorted_wakeup_time_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swtq_req_if.sink   i_req,
    swtq_rsp_if.source o_rsp
);

    swtq_pkg::t_cmd cmd;

    swtq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    swtq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_req.action),
        .i_terminal       (i_req.terminal),
        .i_tag            (i_req.tag),
        .i_keying_seconds (i_req.keying_seconds),
        .i_think_ms       (i_req.think_ms),
        .o_status         (o_rsp.status),
        .o_out_terminal   (o_rsp.out_terminal),
        .o_out_tag        (o_rsp.out_tag),
        .o_delay_ms       (o_rsp.delay_ms),
        .o_fill           (o_rsp.fill)
    );

endmodule

/* hw/rtl/swtq_ctrl.sv */
module swtq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output swtq_pkg::t_cmd   o_cmd
);

    swtq_pkg::t_state r_state, n_state;
    logic             r_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swtq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.apply) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.calc    = 1'b0;
        o_cmd.apply   = 1'b0;
        case (r_state)
            swtq_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = swtq_pkg::S_CALC;
                end
            end
            swtq_pkg::S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = swtq_pkg::S_APPLY;
            end
            swtq_pkg::S_APPLY: begin
                // hold until the output word slot frees up
                if (out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = swtq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swtq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/swtq_datapath.sv */
module swtq_datapath #(
    parameter int unsigned QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swtq_pkg::t_cmd                i_cmd,
    input  logic                          i_action,
    input  logic [swtq_pkg::TERM_W-1:0]   i_terminal,
    input  logic [swtq_pkg::TAG_W-1:0]    i_tag,
    input  logic [swtq_pkg::KEY_W-1:0]    i_keying_seconds,
    input  logic [swtq_pkg::THINK_W-1:0]  i_think_ms,
    output logic [1:0]                    o_status,
    output logic [swtq_pkg::TERM_W-1:0]   o_out_terminal,
    output logic [swtq_pkg::TAG_W-1:0]    o_out_tag,
    output logic [swtq_pkg::TIME_W-1:0]   o_delay_ms,
    output logic [swtq_pkg::FILL_W-1:0]   o_fill
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam int unsigned TW = swtq_pkg::TIME_W;

    // captured word
    logic                          r_action;
    logic [swtq_pkg::TERM_W-1:0]   r_terminal;
    logic [swtq_pkg::TAG_W-1:0]    r_tag;
    logic [swtq_pkg::KEY_W-1:0]    r_keying;
    logic [swtq_pkg::THINK_W-1:0]  r_think;
    logic [TW-1:0]                 r_due_new;

    // queue state
    logic [CW-1:0]                 r_count;
    logic [TW-1:0]                 r_qtime;

    // sorted cell chain, cell 0 holds the earliest due time
    logic [TW-1:0]                 r_due  [QUEUE_DEPTH];
    logic [swtq_pkg::TERM_W-1:0]   r_term [QUEUE_DEPTH];
    logic [swtq_pkg::TAG_W-1:0]    r_ctag [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0]        lt;
    logic                          full;
    logic                          empty;
    logic [CW-1:0]                 count_inc;
    logic [CW-1:0]                 count_dec;

    assign full      = (r_count >= DEPTH_C);
    assign empty     = (r_count == '0);
    assign count_inc = r_count + CW'(1);
    assign count_dec = r_count - CW'(1);

    // cells strictly earlier than the new word stay put; ties go behind the new one
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            lt[i] = (CW'(i) < r_count) && (r_due[i] < r_due_new);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action   <= i_action;
            r_terminal <= i_terminal;
            r_tag      <= i_tag;
            r_keying   <= i_keying_seconds;
            r_think    <= i_think_ms;
        end
        if (i_cmd.calc) begin
            r_due_new <= TW'(r_keying) * TW'(swtq_pkg::KEY_MS_PER_S)
                       + TW'(r_think) + r_qtime;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            if (r_action == swtq_pkg::ACT_ENQ) begin
                if (!full) begin
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        if (!lt[i]) begin
                            if (i == 0 || lt[(i == 0) ? 0 : i - 1]) begin
                                r_due[i]  <= r_due_new;
                                r_term[i] <= r_terminal;
                                r_ctag[i] <= r_tag;
                            end else begin
                                r_due[i]  <= r_due[(i == 0) ? 0 : i - 1];
                                r_term[i] <= r_term[(i == 0) ? 0 : i - 1];
                                r_ctag[i] <= r_ctag[(i == 0) ? 0 : i - 1];
                            end
                        end
                    end
                end
            end else if (!empty) begin
                // pop cell 0, advance the rest
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                    r_due[i]  <= r_due[i + 1];
                    r_term[i] <= r_term[i + 1];
                    r_ctag[i] <= r_ctag[i + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_qtime <= '0;
        end else if (i_cmd.apply) begin
            if (r_action == swtq_pkg::ACT_ENQ) begin
                if (!full) begin
                    r_count <= count_inc;
                end
            end else if (!empty) begin
                r_count <= count_dec;
                r_qtime <= r_due[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            o_out_terminal <= '0;
            o_out_tag      <= '0;
            o_delay_ms     <= '0;
            if (r_action == swtq_pkg::ACT_ENQ) begin
                if (full) begin
                    o_status <= swtq_pkg::ST_FULL;
                    o_fill   <= swtq_pkg::FILL_W'(r_count);
                end else begin
                    o_status <= swtq_pkg::ST_ENQUEUED;
                    o_fill   <= swtq_pkg::FILL_W'(count_inc);
                end
            end else if (empty) begin
                o_status <= swtq_pkg::ST_EMPTY;
                o_fill   <= '0;
            end else begin
                o_status       <= swtq_pkg::ST_DEQUEUED;
                o_out_terminal <= r_term[0];
                o_out_tag      <= r_ctag[0];
                o_delay_ms     <= r_due[0] - r_qtime;
                o_fill         <= swtq_pkg::FILL_W'(count_dec);
            end
        end
    end

endmodule

/* hw/rtl/swtq_checker.sv */
`include "sorted_wakeup_time_queue_unit_assert.svh"

module swtq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [1:0]                    i_status,
    input logic [swtq_pkg::TERM_W-1:0]   i_out_terminal,
    input logic [swtq_pkg::TAG_W-1:0]    i_out_tag,
    input logic [swtq_pkg::TIME_W-1:0]   i_delay_ms,
    input logic [swtq_pkg::FILL_W-1:0]   i_fill
);

    `SWTQ_ASSERT_NEXT(a_out_hold, i_valid && !i_ready, i_valid && $stable(i_status) && $stable(i_delay_ms), "result word changed while stalled")
    `SWTQ_ASSERT_NOW(a_empty_zero, i_valid && i_status == swtq_pkg::ST_EMPTY, i_fill == '0 && i_delay_ms == '0 && i_out_terminal == '0, "empty result not cleared")
    `SWTQ_ASSERT_NOW(a_enq_zero, i_valid && (i_status == swtq_pkg::ST_ENQUEUED || i_status == swtq_pkg::ST_FULL), i_out_terminal == '0 && i_out_tag == '0 && i_delay_ms == '0, "enqueue result carries payload")

endmodule

bind sorted_wakeup_time_queue_unit swtq_checker u_swtq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_rsp.valid),
    .i_ready        (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_out_terminal (o_rsp.out_terminal),
    .i_out_tag      (o_rsp.out_tag),
    .i_delay_ms     (o_rsp.delay_ms),
    .i_fill         (o_rsp.fill)
);
